@@ design/set_assoc_cache_mesi_lru_top_defines.svh @@
// ----------------------------------------------------------------------------
// set_assoc_cache_mesi_lru_top_defines
// assertion macros used by the cache datapath
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_MESI_LRU_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_MESI_LRU_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SACM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SACM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sacm_pkg.sv @@
// ----------------------------------------------------------------------------
// sacm_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package sacm_pkg;

  localparam int SETS_DEF        = 16384;
  localparam int WAYS_DEF        = 4;
  localparam int TAG_WIDTH_DEF   = 12;
  localparam int OFFSET_BITS_DEF = 6;

  // mesi line states
  localparam logic [1:0] MESI_I = 2'd0;
  localparam logic [1:0] MESI_S = 2'd1;
  localparam logic [1:0] MESI_E = 2'd2;
  localparam logic [1:0] MESI_M = 2'd3;

  // access kind
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic clr_we;
    logic load_in;
    logic step_mul;
    logic step_back;
    logic step_fix;
    logic upd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/sacm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sacm_ctrl
// sequencer: clearing pass, address split steps, lookup and update
// ----------------------------------------------------------------------------
module sacm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sacm_pkg::dp_stat_t   stat,
  output sacm_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_BACK  = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.step_mul = 1'b1;
        state_next   = S_BACK;
      end
      S_BACK: begin
        cmd.step_back = 1'b1;
        state_next    = S_FIX;
      end
      S_FIX: begin
        cmd.step_fix = 1'b1;
        state_next   = S_UPD;
      end
      S_UPD: begin
        // hold until the result register can take the beat
        if (stat.out_free) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ design/sacm_dp.sv @@
// ----------------------------------------------------------------------------
// sacm_dp
// address split, set memory, hit/victim select, lru update, counters
// ----------------------------------------------------------------------------
`include "set_assoc_cache_mesi_lru_top_defines.svh"

module sacm_dp #(
  parameter int SETS        = sacm_pkg::SETS_DEF,
  parameter int WAYS        = sacm_pkg::WAYS_DEF,
  parameter int TAG_WIDTH   = sacm_pkg::TAG_WIDTH_DEF,
  parameter int OFFSET_BITS = sacm_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sacm_pkg::ctrl_cmd_t cmd,
  output sacm_pkg::dp_stat_t  stat,
  input  logic                func,
  input  logic [31:0]         address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [1:0]          way,
  output logic [1:0]          line_state,
  output logic                l2_read,
  output logic                replaced,
  output logic [31:0]         hit_total,
  output logic [31:0]         miss_total,
  output logic [31:0]         read_total,
  output logic [31:0]         write_total
);

  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int Q_W     = 32 - OFFSET_BITS;
  localparam int PROD_W  = Q_W + 32;
  localparam int BACK_W  = Q_W + SET_W + 1;
  localparam int WBITS   = TAG_WIDTH + 5;
  localparam int ROW_W   = WAYS * WBITS;
  // floor(2^32 / SETS): quotient estimate is exact or one short
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(SETS));
  localparam logic [1:0]  AGE_MAX = 2'(WAYS - 1);

  // input and address split registers
  logic                 func_reg;
  logic [Q_W-1:0]       q_reg;
  logic [Q_W-1:0]       qe_reg;
  logic [Q_W-1:0]       back_reg;
  logic [SET_W-1:0]     set_reg;
  logic [TAG_WIDTH-1:0] tag_reg;
  logic [PROD_W-1:0]    prod_full;
  logic [BACK_W-1:0]    back_full;
  logic [Q_W-1:0]       rem;
  logic [SET_W-1:0]     set_comb;
  logic [Q_W-1:0]       quo_comb;

  // set memory
  logic [ROW_W-1:0]     mem [SETS];
  logic [ROW_W-1:0]     row_q;
  logic [ROW_W-1:0]     row_new;
  logic [SET_W-1:0]     clr_idx;
  logic                 mem_we;
  logic [SET_W-1:0]     mem_addr;
  logic [ROW_W-1:0]     mem_wdata;

  // unpacked row and lookup
  logic [TAG_WIDTH-1:0] tags   [WAYS];
  logic                 pres   [WAYS];
  logic [1:0]           mesi   [WAYS];
  logic [1:0]           ages   [WAYS];
  logic [1:0]           ages_n [WAYS];
  logic                 found;
  logic                 got;
  logic                 hit_c;
  logic                 repl_c;
  logic [WAY_W-1:0]     wsel;
  logic [1:0]           st_c;
  logic [1:0]           age_old;
  logic                 is_wr;

  logic [31:0]          hit_cnt;
  logic [31:0]          miss_cnt;
  logic [31:0]          rd_cnt;
  logic [31:0]          wr_cnt;

  assign is_wr     = (func_reg == sacm_pkg::FUNC_WRITE);
  assign prod_full = PROD_W'(q_reg) * PROD_W'(RECIP);
  assign back_full = BACK_W'(qe_reg) * BACK_W'(SETS);
  assign rem       = q_reg - back_reg;

  always_comb begin
    if (rem >= Q_W'(SETS)) begin
      set_comb = SET_W'(rem - Q_W'(SETS));
      quo_comb = qe_reg + Q_W'(1);
    end else begin
      set_comb = SET_W'(rem);
      quo_comb = qe_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_reg <= func;
      q_reg    <= address[31:OFFSET_BITS];
    end
    if (cmd.step_mul) begin
      qe_reg <= prod_full[PROD_W-1:32];
    end
    if (cmd.step_back) begin
      // qe * SETS never exceeds q, so the low bits are exact
      back_reg <= back_full[Q_W-1:0];
    end
    if (cmd.step_fix) begin
      set_reg <= set_comb;
      tag_reg <= TAG_WIDTH'(quo_comb);
    end
  end

  // clearing pass index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_we) begin
      clr_idx <= clr_idx + SET_W'(1);
    end
  end

  assign stat.clr_last = (clr_idx == SET_W'(SETS - 1));
  assign stat.out_free = !out_valid || !out_stall;

  assign mem_we    = cmd.clr_we || cmd.upd;
  assign mem_addr  = cmd.clr_we ? clr_idx : set_reg;
  assign mem_wdata = cmd.clr_we ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.step_fix) begin
      row_q <= mem[set_comb];
    end
  end

  // way field layout: {tag, present, mesi, age}
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      tags[i] = row_q[i*WBITS+5 +: TAG_WIDTH];
      pres[i] = row_q[i*WBITS+4];
      mesi[i] = row_q[i*WBITS+2 +: 2];
      ages[i] = row_q[i*WBITS +: 2];
    end
  end

  always_comb begin
    found  = 1'b0;
    got    = 1'b0;
    hit_c  = 1'b0;
    repl_c = 1'b0;
    wsel   = '0;
    st_c   = sacm_pkg::MESI_I;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && pres[i] && (tags[i] == tag_reg)) begin
        found = 1'b1;
        wsel  = WAY_W'(i);
      end
    end
    if (found) begin
      if (mesi[wsel] != sacm_pkg::MESI_I) begin
        hit_c = 1'b1;
        st_c  = is_wr ? sacm_pkg::MESI_M : mesi[wsel];
      end else begin
        // matching line in I refills in place
        st_c = is_wr ? sacm_pkg::MESI_M : sacm_pkg::MESI_S;
      end
    end else begin
      for (int i = 0; i < WAYS; i++) begin
        if (!got && !pres[i]) begin
          got  = 1'b1;
          wsel = WAY_W'(i);
        end
      end
      if (got) begin
        st_c = is_wr ? sacm_pkg::MESI_M : sacm_pkg::MESI_S;
      end else begin
        // last invalid way wins
        for (int i = 0; i < WAYS; i++) begin
          if (mesi[i] == sacm_pkg::MESI_I) begin
            got  = 1'b1;
            wsel = WAY_W'(i);
          end
        end
        if (!got) begin
          wsel   = '0;
          repl_c = 1'b1;
          for (int i = WAYS - 1; i >= 0; i--) begin
            if (ages[i] == 2'd0) begin
              wsel = WAY_W'(i);
            end
          end
        end
        st_c = is_wr ? sacm_pkg::MESI_M : sacm_pkg::MESI_E;
      end
    end
  end

  // true lru: ways more recent than the touched one move down by one
  always_comb begin
    age_old = ages[wsel];
    for (int i = 0; i < WAYS; i++) begin
      ages_n[i] = (ages[i] > age_old) ? (ages[i] - 2'd1) : ages[i];
    end
    ages_n[wsel] = AGE_MAX;
    row_new = row_q;
    for (int i = 0; i < WAYS; i++) begin
      row_new[i*WBITS +: 2] = ages_n[i];
    end
    row_new[32'(wsel)*WBITS+5 +: TAG_WIDTH] = tag_reg;
    row_new[32'(wsel)*WBITS+4]              = 1'b1;
    row_new[32'(wsel)*WBITS+2 +: 2]         = st_c;
  end

  // result register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      rd_cnt    <= '0;
      wr_cnt    <= '0;
    end else begin
      if (cmd.upd) begin
        out_valid <= 1'b1;
        hit_cnt   <= hit_cnt + 32'(hit_c);
        miss_cnt  <= miss_cnt + 32'(!hit_c);
        rd_cnt    <= rd_cnt + 32'(!is_wr);
        wr_cnt    <= wr_cnt + 32'(is_wr);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      hit        <= hit_c;
      way        <= 2'(wsel);
      line_state <= st_c;
      l2_read    <= !hit_c;
      replaced   <= repl_c;
    end
  end

  assign hit_total   = hit_cnt;
  assign miss_total  = miss_cnt;
  assign read_total  = rd_cnt;
  assign write_total = wr_cnt;

  `SACM_ASSERT_NOW(a_upd_free, clk, rst, cmd.upd, stat.out_free, "update while result held")
  `SACM_ASSERT_NEXT(a_upd_valid, clk, rst, cmd.upd, out_valid, "update did not raise valid")
  `SACM_ASSERT_NOW(a_cnt_sum, clk, rst, 1'b1, hit_cnt + miss_cnt == rd_cnt + wr_cnt, "count sums")
  `SACM_ASSERT_NOW(a_hit_flags, clk, rst, out_valid && hit, !l2_read && !replaced, "hit flags")

endmodule

@@ design/set_assoc_cache_mesi_lru_top.sv @@
// each access runs the split steps (multiply, multiply back, fix), then lookup and update
// accesses do not overlap: in_stall stays high until the update step writes the set back
// an access waits in the update step while the previous result beat is still stalled
// reset: synchronous; a clearing pass writes every set empty, in_stall high
// ----------------------------------------------------------------------------
// set_assoc_cache_mesi_lru_top
// set-associative tag/state cache model with mesi states and true lru ages
// ----------------------------------------------------------------------------
module set_assoc_cache_mesi_lru_top #(
  parameter int SETS        = sacm_pkg::SETS_DEF,
  parameter int WAYS        = sacm_pkg::WAYS_DEF,
  parameter int TAG_WIDTH   = sacm_pkg::TAG_WIDTH_DEF,
  parameter int OFFSET_BITS = sacm_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [1:0]  way,
  output logic [1:0]  line_state,
  output logic        l2_read,
  output logic        replaced,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] read_total,
  output logic [31:0] write_total
);

  sacm_pkg::ctrl_cmd_t cmd;
  sacm_pkg::dp_stat_t  stat;

  sacm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sacm_dp #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .TAG_WIDTH   (TAG_WIDTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .address     (address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .way         (way),
    .line_state  (line_state),
    .l2_read     (l2_read),
    .replaced    (replaced),
    .hit_total   (hit_total),
    .miss_total  (miss_total),
    .read_total  (read_total),
    .write_total (write_total)
  );

endmodule
